FILE: rtl/idl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idl_pkg;

   // List geometry. DEPTH must be a power of two: physical slots wrap around
   // the circular buffer by plain truncation of the address.
   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Fixed widths of the transaction fields.
   localparam int CMD_W   = 4;
   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int SIZE_W  = 7;

   localparam int REQ_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((VALUE_W + SIZE_W + 1 + 7) / 8) * 8;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUT_HEAD    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PUT_TAIL    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT      = 4'd2;
   localparam logic [CMD_W-1:0] CMD_GET         = 4'd3;
   localparam logic [CMD_W-1:0] CMD_GET_HEAD    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_GET_TAIL    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DELETE      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_REMOVE_HEAD = 4'd7;
   localparam logic [CMD_W-1:0] CMD_REMOVE_TAIL = 4'd8;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 4'd9;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INDEX = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VALUE_W-1:0] read_value;
      logic [SIZE_W-1:0]  size;
      logic               is_empty;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/indexed_deque_list_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata (lowest bit up)                          tuser
// req_      in         position[5:0], value[37:6], zero[39:38]        command[3:0]
// rsp_      out        read_value[31:0], size[38:32], is_empty[39]    status[1:0]
//
// Put, remove, clear and every error are settled in the cycle the request is taken;
// get, get_head and get_tail pass through a read state for the registered read of
// the entry memory. Insert and delete at a position shift the entries behind the
// position one slot per cycle through the single memory port pair.
// Reset is synchronous and clears only the control state; the entry memory needs
// no clearing pass, since only slots below the count are ever read.
// Results queue in a two-entry output buffer, so a stalled result side holds the
// block off only when both entries are full.

module indexed_deque_list_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // position, value, zero padding (from the lowest bit up)
   input  wire logic [idl_pkg::REQ_TDATA_W-1:0] req_tdata,
   // command
   input  wire logic [idl_pkg::CMD_W-1:0]       req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // read_value, size, is_empty (from the lowest bit up)
   output logic [idl_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // status
   output logic [idl_pkg::STAT_W-1:0]           rsp_tuser
);
   import idl_pkg::*;

   // Sequencer states.
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_READ      = 3'd1;
   localparam logic [2:0] S_SHIFT_UP  = 3'd2;
   localparam logic [2:0] S_WRITE_VAL = 3'd3;
   localparam logic [2:0] S_SHIFT_DN  = 3'd4;

   // The list lives in a circular buffer: logical position p sits in physical
   // slot head+p. Head and tail operations only move the head or the count;
   // insert and delete shift the entries behind the position, one per cycle.
   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] mem_rdata_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [ADDR_W-1:0]     mem_raddr;

   logic [2:0]            state_ff,  state_in;
   logic [ADDR_W-1:0]     head_ff,   head_in;
   logic [CNT_W-1:0]      count_ff,  count_in;
   logic [ADDR_W-1:0]     cur_ff,    cur_in;
   logic [ADDR_W-1:0]     pos_ff,    pos_in;
   logic [DATA_WIDTH-1:0] value_ff,  value_in;

   // Two-entry result buffer; slot 0 drives the result channel.
   rsp_type               slot0_ff, slot1_ff;
   logic                  slot0_valid_ff, slot1_valid_ff;
   logic                  push;
   rsp_type               push_data;
   logic                  pop;

   // Request fields.
   logic [CMD_W-1:0]      req_command;
   logic [POS_W-1:0]      req_position;
   logic [VALUE_W-1:0]    req_value;
   logic                  req_accept;

   assign req_command  = req_tuser;
   assign req_position = req_tdata[POS_W-1:0];
   assign req_value    = req_tdata[POS_W+VALUE_W-1:POS_W];

   // A new transaction is taken only between commands, and only while the
   // result buffer still has room for the result it will cause.
   assign req_tready = (state_ff == S_IDLE) && !slot1_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = slot0_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({slot0_ff.is_empty, slot0_ff.size, slot0_ff.read_value});
   assign rsp_tuser  = slot0_ff.status;
   assign pop        = slot0_valid_ff && rsp_tready;

   // Entry memory: one write port, one read port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      logic                  full;
      logic                  empty;
      logic [CNT_W-1:0]      pos_cnt;
      logic                  in_range;
      logic [ADDR_W-1:0]     pos_addr;
      logic [ADDR_W-1:0]     last_off;
      logic [DATA_WIDTH-1:0] new_value;
      logic [STAT_W-1:0]     push_status;
      logic [VALUE_W-1:0]    push_read;

      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      pos_cnt   = CNT_W'(req_position);
      in_range  = (pos_cnt < count_ff);
      pos_addr  = ADDR_W'(req_position);
      last_off  = ADDR_W'(count_ff - CNT_W'(1));
      new_value = DATA_WIDTH'(req_value);

      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      mem_we      = 1'b0;
      mem_waddr   = head_ff;
      mem_wdata   = new_value;
      mem_raddr   = head_ff;
      push        = 1'b0;
      push_status = STAT_OK;
      push_read   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_command)
                  CMD_PUT_HEAD: begin
                     push = 1'b1;
                     if (full) begin
                        push_status = STAT_FULL;
                     end else begin
                        head_in   = head_ff - ADDR_W'(1);
                        mem_we    = 1'b1;
                        mem_waddr = head_ff - ADDR_W'(1);
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_PUT_TAIL: begin
                     push = 1'b1;
                     if (full) begin
                        push_status = STAT_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = head_ff + ADDR_W'(count_ff);
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (req_position == '0) begin
                        // Insert at the front behaves exactly as put at head.
                        push = 1'b1;
                        if (full) begin
                           push_status = STAT_FULL;
                        end else begin
                           head_in   = head_ff - ADDR_W'(1);
                           mem_we    = 1'b1;
                           mem_waddr = head_ff - ADDR_W'(1);
                           count_in  = count_ff + CNT_W'(1);
                        end
                     end else if (!in_range) begin
                        push        = 1'b1;
                        push_status = STAT_INDEX;
                     end else if (full) begin
                        push        = 1'b1;
                        push_status = STAT_FULL;
                     end else begin
                        // Start moving the tail entry up by one slot.
                        mem_raddr = head_ff + last_off;
                        cur_in    = last_off;
                        pos_in    = pos_addr;
                        value_in  = new_value;
                        state_in  = S_SHIFT_UP;
                     end
                  end
                  CMD_GET: begin
                     if (!in_range) begin
                        push        = 1'b1;
                        push_status = STAT_INDEX;
                     end else begin
                        mem_raddr = head_ff + pos_addr;
                        state_in  = S_READ;
                     end
                  end
                  CMD_GET_HEAD: begin
                     if (empty) begin
                        push        = 1'b1;
                        push_status = STAT_INDEX;
                     end else begin
                        mem_raddr = head_ff;
                        state_in  = S_READ;
                     end
                  end
                  CMD_GET_TAIL: begin
                     if (empty) begin
                        push        = 1'b1;
                        push_status = STAT_INDEX;
                     end else begin
                        mem_raddr = head_ff + last_off;
                        state_in  = S_READ;
                     end
                  end
                  CMD_DELETE: begin
                     if (!in_range) begin
                        push        = 1'b1;
                        push_status = STAT_INDEX;
                     end else if (pos_cnt == count_ff - CNT_W'(1)) begin
                        // Deleting the tail needs no shift.
                        push     = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        mem_raddr = head_ff + pos_addr + ADDR_W'(1);
                        cur_in    = pos_addr + ADDR_W'(1);
                        state_in  = S_SHIFT_DN;
                     end
                  end
                  CMD_REMOVE_HEAD: begin
                     push = 1'b1;
                     if (empty) begin
                        push_status = STAT_INDEX;
                     end else begin
                        head_in  = head_ff + ADDR_W'(1);
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_REMOVE_TAIL: begin
                     push = 1'b1;
                     if (empty) begin
                        push_status = STAT_INDEX;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_CLEAR: begin
                     push     = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     push        = 1'b1;
                     push_status = STAT_INDEX;
                  end
               endcase
            end
         end
         S_READ: begin
            push      = 1'b1;
            push_read = VALUE_W'(mem_rdata_ff);
            state_in  = S_IDLE;
         end
         S_SHIFT_UP: begin
            // Entry cur was read last cycle; it moves to cur+1. The read of
            // cur-1 and the write of cur+1 never meet in the same slot.
            mem_we    = 1'b1;
            mem_waddr = head_ff + cur_ff + ADDR_W'(1);
            mem_wdata = mem_rdata_ff;
            if (cur_ff == pos_ff) begin
               state_in = S_WRITE_VAL;
            end else begin
               mem_raddr = head_ff + cur_ff - ADDR_W'(1);
               cur_in    = cur_ff - ADDR_W'(1);
            end
         end
         S_WRITE_VAL: begin
            mem_we    = 1'b1;
            mem_waddr = head_ff + pos_ff;
            mem_wdata = value_ff;
            count_in  = count_ff + CNT_W'(1);
            push      = 1'b1;
            state_in  = S_IDLE;
         end
         S_SHIFT_DN: begin
            // Entry cur moves down to cur-1 until the tail has moved.
            mem_we    = 1'b1;
            mem_waddr = head_ff + cur_ff - ADDR_W'(1);
            mem_wdata = mem_rdata_ff;
            if (CNT_W'(cur_ff) == count_ff - CNT_W'(1)) begin
               count_in = count_ff - CNT_W'(1);
               push     = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_raddr = head_ff + cur_ff + ADDR_W'(1);
               cur_in    = cur_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      push_data.status     = push_status;
      push_data.read_value = push_read;
      push_data.size       = SIZE_W'(count_in);
      push_data.is_empty   = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      pos_ff   <= pos_in;
      value_ff <= value_in;
   end

   // Result buffer. Slot 1 is only ever occupied while slot 0 is, and a push
   // never finds both slots full because a transaction is refused then.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_valid_ff <= 1'b0;
         slot1_valid_ff <= 1'b0;
      end else if (!slot0_valid_ff || pop) begin
         if (slot1_valid_ff) begin
            slot0_valid_ff <= 1'b1;
            slot1_valid_ff <= push;
         end else begin
            slot0_valid_ff <= push;
            slot1_valid_ff <= 1'b0;
         end
      end else if (push) begin
         slot1_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!slot0_valid_ff || pop) begin
         if (slot1_valid_ff) begin
            slot0_ff <= slot1_ff;
            slot1_ff <= push_data;
         end else begin
            slot0_ff <= push_data;
         end
      end else if (push) begin
         slot1_ff <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/idl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module idl_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [idl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [idl_pkg::STAT_W-1:0]      rsp_tuser
);
   import idl_pkg::*;

   logic [VALUE_W-1:0] rsp_read_value;
   logic [SIZE_W-1:0]  rsp_size;
   logic               rsp_is_empty;

   assign rsp_read_value = rsp_tdata[VALUE_W-1:0];
   assign rsp_size       = rsp_tdata[VALUE_W+SIZE_W-1:VALUE_W];
   assign rsp_is_empty   = rsp_tdata[VALUE_W+SIZE_W];

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The empty flag agrees with the reported count.
   a_empty_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_is_empty == (rsp_size == '0)))
      else $error("empty flag disagrees with size");

   // The count never exceeds the list depth and the status is a defined code.
   a_size_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_size <= SIZE_W'(DEPTH)) &&
                     (rsp_tuser == STAT_OK || rsp_tuser == STAT_INDEX ||
                      rsp_tuser == STAT_FULL))
      else $error("size beyond depth or undefined status");

   // A failed command returns no data.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_read_value == '0)
      else $error("read value not zero on error");

   // A full list is only reported while the list actually holds DEPTH entries.
   a_full_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_FULL |-> rsp_size == SIZE_W'(DEPTH))
      else $error("full status with list not full");

endmodule

bind indexed_deque_list_core idl_checker u_idl_checker (.*);

`default_nettype wire

FILE: tb/deque_list_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Watches both channels of the list core, keeps a shadow copy of the list,
// and compares every result transaction with the oldest expected one.
module deque_list_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [idl_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [idl_pkg::CMD_W-1:0]       req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [idl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic [idl_pkg::STAT_W-1:0]      rsp_tuser,
   output int                                   failures,
   output int                                   outstanding,
   output logic [idl_pkg::SIZE_W-1:0]           list_size
);

   import idl_pkg::*;

   localparam int REPORT_LIMIT = 200;

   logic [VALUE_W-1:0] list_words [DEPTH];
   int unsigned        list_count;
   rsp_type            expected_results [$];
   int                 error_total;

   function automatic void open_slot(int unsigned at, logic [VALUE_W-1:0] word);
      for (int unsigned i = list_count; i > at; i--)
         list_words[i] = list_words[i - 1];
      list_words[at] = word;
      list_count++;
   endfunction

   function automatic void close_slot(int unsigned at);
      for (int unsigned i = at; i + 1 < list_count; i++)
         list_words[i] = list_words[i + 1];
      list_count--;
   endfunction

   // Applies one command to the shadow list and returns the result it should give.
   function automatic rsp_type apply_list_command(logic [CMD_W-1:0] cmd,
                                                  logic [POS_W-1:0] pos,
                                                  logic [VALUE_W-1:0] word);
      rsp_type res;
      logic    full;
      full           = (list_count >= DEPTH);
      res.status     = STAT_OK;
      res.read_value = '0;
      case (cmd)
         CMD_PUT_HEAD: begin
            if (full) res.status = STAT_FULL;
            else open_slot(0, word);
         end
         CMD_PUT_TAIL: begin
            if (full) res.status = STAT_FULL;
            else open_slot(list_count, word);
         end
         CMD_INSERT: begin
            if (pos == 0) begin
               if (full) res.status = STAT_FULL;
               else open_slot(0, word);
            end else if (pos >= list_count) res.status = STAT_INDEX;
            else if (full) res.status = STAT_FULL;
            else open_slot(pos, word);
         end
         CMD_GET: begin
            if (pos >= list_count) res.status = STAT_INDEX;
            else res.read_value = list_words[pos];
         end
         CMD_GET_HEAD: begin
            if (list_count == 0) res.status = STAT_INDEX;
            else res.read_value = list_words[0];
         end
         CMD_GET_TAIL: begin
            if (list_count == 0) res.status = STAT_INDEX;
            else res.read_value = list_words[list_count - 1];
         end
         CMD_DELETE: begin
            if (pos >= list_count) res.status = STAT_INDEX;
            else close_slot(pos);
         end
         CMD_REMOVE_HEAD: begin
            if (list_count == 0) res.status = STAT_INDEX;
            else close_slot(0);
         end
         CMD_REMOVE_TAIL: begin
            if (list_count == 0) res.status = STAT_INDEX;
            else close_slot(list_count - 1);
         end
         CMD_CLEAR: list_count = 0;
         default: res.status = STAT_INDEX;
      endcase
      res.size     = SIZE_W'(list_count);
      res.is_empty = (list_count == 0);
      return res;
   endfunction

   function automatic void compare_field(string field, logic [VALUE_W-1:0] want,
                                         logic [VALUE_W-1:0] got);
      if (want !== got) begin
         error_total++;
         if (error_total <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         list_count = 0;
         expected_results.delete();
      end else begin
         // A result is never produced in the cycle its command is taken, so the
         // result side is handled before the command side.
         if (rsp_tvalid && rsp_tready) begin
            seen.status     = rsp_tuser;
            seen.read_value = rsp_tdata[VALUE_W-1:0];
            seen.size       = rsp_tdata[VALUE_W +: SIZE_W];
            seen.is_empty   = rsp_tdata[VALUE_W + SIZE_W];
            if (expected_results.size() == 0) begin
               error_total++;
               if (error_total <= REPORT_LIMIT)
                  $display("%0t ns: unexpected result, expected none, got 0x%0h",
                           $time, seen);
            end else begin
               want = expected_results.pop_front();
               compare_field("status", VALUE_W'(want.status), VALUE_W'(seen.status));
               compare_field("read_value", want.read_value, seen.read_value);
               compare_field("size", VALUE_W'(want.size), VALUE_W'(seen.size));
               compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(seen.is_empty));
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_list_command(req_tuser,
                                                          req_tdata[POS_W-1:0],
                                                          req_tdata[POS_W +: VALUE_W]));
      end
      failures    <= error_total;
      outstanding <= expected_results.size();
      list_size   <= SIZE_W'(list_count);
   end

   initial begin
      error_total = 0;
      list_count  = 0;
      failures    = 0;
      outstanding = 0;
      list_size   = '0;
   end

endmodule

`default_nettype wire

FILE: tb/tb_indexed_deque_list_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Top of the list core testbench. It drives command transactions, drives the
// ready of the result channel, and gives the verdict; all prediction and
// comparison lives in the checker instantiated beside the core.
module tb_indexed_deque_list_core;

   import idl_pkg::*;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 8;
   localparam int RANDOM_ITEMS  = 1125;
   // Points in the random part where the result side holds off for a long time,
   // where the sender waits for the core to drain, and from which on nobody idles.
   localparam int HOLD_AT       = 300;
   localparam int DRAIN_AT      = 650;
   localparam int CALM_FROM     = RANDOM_ITEMS - 150;
   localparam int HOLD_CYCLES   = 200;
   // An insert just behind the head of an almost full list is the slowest
   // command, since it shifts nearly every entry, so this is ample for anything still in flight.
   localparam int SETTLE_CYCLES = 2 * DEPTH + 20;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam logic [POS_W-1:0]   POS_MAX  = '1;
   localparam logic [VALUE_W-1:0] ALL_ONES = '1;

   typedef enum int { TREND_GROW, TREND_SHRINK, TREND_MIXED } fill_trend_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]      rsp_tuser;

   int                     failures;
   int                     outstanding;
   logic [SIZE_W-1:0]      list_size;

   // Requests for a long hold on the result side are counted here by the sender
   // and served by the ready process, so that each variable has a single writer.
   int                     hold_requests = 0;
   int                     holds_served  = 0;
   logic                   calm          = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   indexed_deque_list_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   deque_list_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .failures    (failures),
      .outstanding (outstanding),
      .list_size   (list_size)
   );

   // Offers one command transaction and returns at the edge at which it is taken.
   // Outside the calm stretch the valid is sometimes dropped for a short burst
   // first. The drop and the raise never fall in the same time step, since the
   // task waits on a clock edge between them.
   task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] word);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_TDATA_W - POS_W - VALUE_W){1'b0}}, word, pos};
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until the checker has seen every result it expects. The count is
   // registered in the checker, hence the first wait.
   task automatic wait_for_drain();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // The command mix follows the current trend, so that the list swings between
   // empty and full and spends a fair time at either end.
   function automatic logic [CMD_W-1:0] pick_command(fill_trend_type trend);
      int roll;
      int grow_share;
      int read_share;
      roll = $urandom_range(0, 99);
      case (trend)
         TREND_GROW:   begin grow_share = 70; read_share = 18; end
         TREND_SHRINK: begin grow_share = 13; read_share = 20; end
         default:      begin grow_share = 38; read_share = 25; end
      endcase
      if (roll < 2)
         return CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, (1 << CMD_W) - 1));
      if (roll < 3 && trend == TREND_MIXED)
         return CMD_CLEAR;
      if (roll < grow_share) begin
         case ($urandom_range(0, 3))
            0:       return CMD_PUT_HEAD;
            1:       return CMD_PUT_TAIL;
            default: return CMD_INSERT;
         endcase
      end
      if (roll < grow_share + read_share) begin
         case ($urandom_range(0, 2))
            0:       return CMD_GET;
            1:       return CMD_GET_HEAD;
            default: return CMD_GET_TAIL;
         endcase
      end
      case ($urandom_range(0, 2))
         0:       return CMD_DELETE;
         1:       return CMD_REMOVE_HEAD;
         default: return CMD_REMOVE_TAIL;
      endcase
   endfunction

   // Mostly a position inside the list, sometimes the first one past its end,
   // and sometimes anything at all.
   function automatic logic [POS_W-1:0] pick_position(int unsigned fill);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7 && fill > 0)
         return POS_W'($urandom_range(0, fill - 1));
      if (roll < 8)
         return POS_W'((fill > POS_MAX) ? POS_MAX : fill);
      return POS_W'($urandom_range(0, POS_MAX));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return ALL_ONES;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Ready of the result side. Short stalls come at random outside the calm
   // stretch; a requested long hold keeps the ready low while the sender keeps
   // offering commands, so that the output buffer fills and the core stalls.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      fill_trend_type trend;
      trend = TREND_GROW;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: the empty list first, then a short list built and taken
      // apart again, the unused command codes, and clear.
      send_command(CMD_GET_HEAD, '0, '0);
      send_command(CMD_REMOVE_TAIL, '0, '0);
      send_command(CMD_GET, '0, '0);
      send_command(CMD_INSERT, POS_W'(5), ALL_ONES);
      send_command(CMD_PUT_TAIL, '0, ALL_ONES);
      send_command(CMD_PUT_HEAD, POS_MAX, '0);
      // Insert at position zero stands in for a put at the head.
      send_command(CMD_INSERT, '0, 32'hA5A5_A5A5);
      send_command(CMD_INSERT, POS_W'(1), 32'h1234_5678);
      send_command(CMD_INSERT, POS_MAX, 32'h5A5A_5A5A);
      send_command(CMD_GET, POS_W'(3), '0);
      send_command(CMD_GET, POS_MAX, ALL_ONES);
      send_command(CMD_GET_TAIL, '0, '0);
      send_command(CMD_GET_HEAD, '0, '0);
      send_command(CMD_DELETE, POS_W'(1), '0);
      send_command(CMD_DELETE, POS_MAX, '0);
      send_command(CMD_REMOVE_HEAD, '0, '0);
      send_command(CMD_REMOVE_TAIL, '0, '0);
      for (int code = int'(CMD_CLEAR) + 1; code < (1 << CMD_W); code++)
         send_command(CMD_W'(code), POS_MAX, ALL_ONES);
      send_command(CMD_CLEAR, '0, '0);
      send_command(CMD_GET_TAIL, '0, '0);

      // Random part.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT)
            hold_requests <= hold_requests + 1;
         if (n == DRAIN_AT) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
         end
         if (n == CALM_FROM)
            calm <= 1'b1;
         // Stay near the full mark for a while before turning round.
         if (trend == TREND_GROW && list_size >= DEPTH && $urandom_range(0, 5) == 0)
            trend = TREND_SHRINK;
         else if (trend == TREND_SHRINK && list_size == 0)
            trend = TREND_GROW;
         else if ($urandom_range(0, 59) == 0)
            trend = fill_trend_type'($urandom_range(0, 2));
         send_command(pick_command(trend), pick_position(list_size), pick_value());
      end
      req_tvalid <= 1'b0;

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("indexed_deque_list_core verification clean");
      else
         $display("indexed_deque_list_core verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("indexed_deque_list_core verification failed");
      $finish;
   end

endmodule

`default_nettype wire
